// ===== rtl/core/mix_minus_mixer_vad_defines.svh =====
// Assertion macros used by the mixer top level
`ifndef MIX_MINUS_MIXER_VAD_DEFINES_SVH
`define MIX_MINUS_MIXER_VAD_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define MMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define MMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mmv_pkg.sv =====
// Types, widths and helpers shared by the mixer modules
package mmv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int NUM_PEERS  = 4;
  localparam int NUM_LANES  = NUM_PEERS + 1;
  localparam int SQ_W       = 31;
  localparam int ENERGY_W   = 40;
  localparam int CNT_W      = 12;
  localparam int THR_W      = 15;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int FLEN_W     = 13;
  localparam int LIMIT_W    = THR_SQ_W + FLEN_W;
  localparam int SUM_W      = 19;
  localparam int MASK_W     = NUM_LANES;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIC_MUTED        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_DEAFENED   = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd500;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mic_sample;
    logic signed [SAMPLE_W-1:0] peer_sample_0;
    logic signed [SAMPLE_W-1:0] peer_sample_1;
    logic signed [SAMPLE_W-1:0] peer_sample_2;
    logic signed [SAMPLE_W-1:0] peer_sample_3;
    logic [NUM_PEERS-1:0]       active_mask;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_minus_0;
    logic signed [SAMPLE_W-1:0] mix_minus_1;
    logic signed [SAMPLE_W-1:0] mix_minus_2;
    logic signed [SAMPLE_W-1:0] mix_minus_3;
    logic signed [SAMPLE_W-1:0] local_mix;
    logic [MASK_W-1:0]          speaking_mask;
    logic                       frame_last;
  } out_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]                 mic;
    logic [SAMPLE_W-1:0]                 mic_mix;
    logic [NUM_PEERS-1:0][SAMPLE_W-1:0]  peer;
    logic [NUM_PEERS-1:0]                act;
    logic                                last;
  } s1_word_t;

  typedef struct packed {
    logic sq_ld;
    logic acc_ld;
    logic last;
  } lane_ctl_t;

  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > SUM_W'(signed'(32767))) begin
      r = 16'h7FFF;
    end else if (v < SUM_W'(signed'(-32768))) begin
      r = 16'h8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mmv_lane.sv =====
// One lane: sample square and frame energy accumulator with speech test
module mmv_lane (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [mmv_pkg::SAMPLE_W-1:0]    sample_i,
  input  mmv_pkg::lane_ctl_t                     ctl_i,
  input  logic [mmv_pkg::LIMIT_W-1:0]            limit_i,
  output logic                                   speak_o
);

  logic signed [2*mmv_pkg::SAMPLE_W-1:0] prod;
  logic [mmv_pkg::SQ_W-1:0]              sq_q;
  logic [mmv_pkg::ENERGY_W-1:0]          energy_q, energy_d;
  logic [mmv_pkg::ENERGY_W:0]            sum;
  logic [mmv_pkg::ENERGY_W-1:0]          sum_sat;

  assign prod = sample_i * sample_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sq_ld) begin
      sq_q <= prod[mmv_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    sum     = {1'b0, energy_q} + (mmv_pkg::ENERGY_W+1)'(sq_q);
    sum_sat = sum[mmv_pkg::ENERGY_W] ? '1 : sum[mmv_pkg::ENERGY_W-1:0];
    speak_o = ctl_i.last &&
              ((mmv_pkg::LIMIT_W)'(sum_sat) > limit_i);
    energy_d = energy_q;
    if (ctl_i.acc_ld) begin
      energy_d = ctl_i.last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else begin
      energy_q <= energy_d;
    end
  end

endmodule

// ===== rtl/core/mmv_mix.sv =====
// Merge stage: mix-minus per peer lane and local playback mix
module mmv_mix (
  input  logic                                        clk_i,
  input  mmv_pkg::s1_word_t                           s1_i,
  input  logic                                        ld_i,
  input  logic                                        deafened_i,
  output logic [mmv_pkg::NUM_PEERS-1:0][mmv_pkg::SAMPLE_W-1:0] mix_minus_o,
  output logic [mmv_pkg::SAMPLE_W-1:0]                local_mix_o
);

  logic signed [mmv_pkg::SUM_W-1:0] total;
  logic signed [mmv_pkg::SUM_W-1:0] mic_ext;
  logic [mmv_pkg::NUM_PEERS-1:0][mmv_pkg::SAMPLE_W-1:0] mix_d;
  logic [mmv_pkg::SAMPLE_W-1:0] local_d;

  always_comb begin
    total   = '0;
    mic_ext = (mmv_pkg::SUM_W)'($signed(s1_i.mic_mix));
    for (int k = 0; k < mmv_pkg::NUM_PEERS; k++) begin
      total = total + (mmv_pkg::SUM_W)'($signed(s1_i.peer[k]));
    end
    for (int k = 0; k < mmv_pkg::NUM_PEERS; k++) begin
      mix_d[k] = s1_i.act[k] ?
                 mmv_pkg::sat16(mic_ext + total - (mmv_pkg::SUM_W)'($signed(s1_i.peer[k]))) :
                 '0;
    end
    local_d = deafened_i ? '0 : mmv_pkg::sat16(total);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      mix_minus_o <= mix_d;
      local_mix_o <= local_d;
    end
  end

endmodule

// ===== rtl/core/mix_minus_mixer_vad.sv =====
// Top level: mix-minus conference mixer with per-lane voice activity flags
//
// Input channel in_valid_i / in_stall_o carries one sample time per word: the
// mic sample, four peer samples and the active peer mask. Output channel
// out_valid_o / out_stall_i returns one word per input word, in order: four
// mix-minus samples, the local playback mix, the speaking mask and frame_last.
// Accepted words pass s1, s2 and the output register; with no stall a new word
// is taken every cycle. Five lanes (mic and four peers) square and accumulate
// energy in parallel, the merge stage forms the sums, and the output register
// collects the speaking bits on the last sample of each frame.
// The speech limit is threshold squared times FRAME_LEN, rebuilt from the
// threshold register through thr_sq_q and then limit_q after a write.
// Reset clears energies, the frame counter and all valids, and loads the
// register defaults. When the receiver stalls, the pipeline fills up and then
// in_stall_o rises; it falls as soon as the output word is taken.
`include "mix_minus_mixer_vad_defines.svh"
module mix_minus_mixer_vad #(
  parameter int PEER_LANES = 4,
  parameter int FRAME_LEN  = 960
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mmv_pkg::in_word_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mmv_pkg::out_word_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mmv_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mmv_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam logic [mmv_pkg::CNT_W-1:0]  LastCount = mmv_pkg::CNT_W'(FRAME_LEN - 1);
  localparam logic [mmv_pkg::FLEN_W-1:0] FrameLen  = mmv_pkg::FLEN_W'(FRAME_LEN);
  localparam logic [mmv_pkg::THR_SQ_W-1:0] ThrSqReset =
    mmv_pkg::THR_SQ_W'(int'(mmv_pkg::THR_RESET) * int'(mmv_pkg::THR_RESET));
  localparam logic [mmv_pkg::LIMIT_W-1:0] LimitReset =
    mmv_pkg::LIMIT_W'(longint'(ThrSqReset) * longint'(FRAME_LEN));

  logic [mmv_pkg::THR_W-1:0]    thr_q;
  logic                         muted_q, deafened_q;
  logic [mmv_pkg::THR_SQ_W-1:0] thr_sq_q;
  logic [mmv_pkg::LIMIT_W-1:0]  limit_q;
  logic [mmv_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  logic en1, en2, en_out, in_acc, last_in;
  logic s1_valid_q, s2_valid_q, s2_last_q, out_valid_q;
  mmv_pkg::s1_word_t  s1_q, s1_d;
  mmv_pkg::out_word_t out_q;

  logic [mmv_pkg::NUM_PEERS-1:0][mmv_pkg::SAMPLE_W-1:0] in_peer;
  logic [mmv_pkg::NUM_PEERS-1:0][mmv_pkg::SAMPLE_W-1:0] mix_minus;
  logic [mmv_pkg::SAMPLE_W-1:0] local_mix;
  logic [mmv_pkg::NUM_LANES-1:0][mmv_pkg::SAMPLE_W-1:0] lane_sample;
  logic [mmv_pkg::NUM_LANES-1:0] speak;
  mmv_pkg::lane_ctl_t lane_ctl;

  // configuration registers and speech limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= mmv_pkg::THR_RESET;
      muted_q    <= 1'b0;
      deafened_q <= 1'b0;
      thr_sq_q   <= ThrSqReset;
      limit_q    <= LimitReset;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mmv_pkg::CFG_SPEECH_THRESHOLD: thr_q <= cfg_wdata_i;
          mmv_pkg::CFG_MIC_MUTED:        muted_q <= cfg_wdata_i[0];
          mmv_pkg::CFG_LOCAL_DEAFENED:   deafened_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      thr_sq_q <= mmv_pkg::THR_SQ_W'(thr_q) * mmv_pkg::THR_SQ_W'(thr_q);
      limit_q  <= mmv_pkg::LIMIT_W'(thr_sq_q) * mmv_pkg::LIMIT_W'(FrameLen);
    end
  end

  // pipeline enables
  assign en_out     = !out_valid_q || !out_stall_i;
  assign en2        = !s2_valid_q || en_out;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;
  assign in_acc     = in_valid_i && en1;

  assign last_in = cnt_q >= LastCount;
  assign cnt_d   = last_in ? '0 : cnt_q + 1'b1;

  assign in_peer[0] = in_data_i.peer_sample_0;
  assign in_peer[1] = in_data_i.peer_sample_1;
  assign in_peer[2] = in_data_i.peer_sample_2;
  assign in_peer[3] = in_data_i.peer_sample_3;

  always_comb begin
    s1_d.mic     = in_data_i.mic_sample;
    s1_d.mic_mix = muted_q ? '0 : in_data_i.mic_sample;
    s1_d.last    = last_in;
    for (int k = 0; k < mmv_pkg::NUM_PEERS; k++) begin
      s1_d.act[k]  = in_data_i.active_mask[k] && (k < PEER_LANES);
      s1_d.peer[k] = s1_d.act[k] ? in_peer[k] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en_out) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (en2 && s1_valid_q) begin
      s2_last_q <= s1_q.last;
    end
    if (en_out && s2_valid_q) begin
      out_q.mix_minus_0   <= mix_minus[0];
      out_q.mix_minus_1   <= mix_minus[1];
      out_q.mix_minus_2   <= mix_minus[2];
      out_q.mix_minus_3   <= mix_minus[3];
      out_q.local_mix     <= local_mix;
      out_q.speaking_mask <= speak;
      out_q.frame_last    <= s2_last_q;
    end
  end

  assign lane_ctl.sq_ld  = en2 && s1_valid_q;
  assign lane_ctl.acc_ld = en_out && s2_valid_q;
  assign lane_ctl.last   = s2_last_q;

  assign lane_sample[0] = s1_q.mic;
  for (genvar k = 0; k < mmv_pkg::NUM_PEERS; k++) begin : g_peer_sample
    assign lane_sample[k+1] = s1_q.peer[k];
  end

  for (genvar l = 0; l < mmv_pkg::NUM_LANES; l++) begin : g_lane
    mmv_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i ($signed(lane_sample[l])),
      .ctl_i    (lane_ctl),
      .limit_i  (limit_q),
      .speak_o  (speak[l])
    );
  end

  mmv_mix u_mix (
    .clk_i       (clk_i),
    .s1_i        (s1_q),
    .ld_i        (lane_ctl.sq_ld),
    .deafened_i  (deafened_q),
    .mix_minus_o (mix_minus),
    .local_mix_o (local_mix)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MMV_ASSERT_NOW(a_mask_only_on_last, out_valid_o && !out_data_o.frame_last, out_data_o.speaking_mask == '0, "speaking mask set outside frame end")
  `MMV_ASSERT_NEXT(a_count_wraps, in_acc && last_in, cnt_q == '0, "frame counter did not restart")
  `MMV_ASSERT_NOW(a_no_stall_when_empty, !out_valid_q, !in_stall_o, "input stalled with empty output")

endmodule
